// ----- design/ctok_pkg.sv -----
// ----------------------------------------------------------------------------
// ctok_pkg
// Shared types, token kinds and the scanner transition function of the lexer.
// ----------------------------------------------------------------------------
package ctok_pkg;

  localparam int unsigned LEN_BITS_DEF  = 16;
  localparam int unsigned LINE_BITS_DEF = 20;
  localparam int unsigned MAX_RES       = 3;

  typedef enum logic [4:0] {
    Q_IDLE, Q_IDENT, Q_NUM, Q_DOT, Q_EXP, Q_DOTDOT, Q_WIDE, Q_STR, Q_STRESC,
    Q_CHR, Q_CHRESC, Q_SPACE, Q_PLUS, Q_MINUS, Q_SLASH, Q_BLOCK, Q_BLOCKSTAR,
    Q_LINECMT, Q_STAR, Q_PCT, Q_GT, Q_GTGT, Q_LT, Q_LTLT, Q_BAR, Q_AMP,
    Q_BANG, Q_EQ, Q_CARET, Q_HASH
  } scan_state_e;

  typedef enum logic [3:0] {
    OP_GO, OP_TAKE, OP_STOP, OP_NL, OP_CMTNL, OP_CMTEND, OP_LITNL, OP_DOTS,
    OP_LINEEND
  } scan_op_e;

  typedef logic [5:0] kind_t;
  typedef logic [1:0] err_t;

  localparam kind_t K_NAME     = 6'd0;
  localparam kind_t K_NUMBER   = 6'd1;
  localparam kind_t K_ELLIPSIS = 6'd2;
  localparam kind_t K_STRING   = 6'd3;
  localparam kind_t K_CHAR     = 6'd4;
  localparam kind_t K_NL       = 6'd5;
  localparam kind_t K_WS       = 6'd6;
  localparam kind_t K_DOT      = 6'd7;
  localparam kind_t K_PLUS     = 6'd8;
  localparam kind_t K_INC      = 6'd9;
  localparam kind_t K_PLUS_EQ  = 6'd10;
  localparam kind_t K_MINUS    = 6'd11;
  localparam kind_t K_DEC      = 6'd12;
  localparam kind_t K_MINUS_EQ = 6'd13;
  localparam kind_t K_ARROW    = 6'd14;
  localparam kind_t K_STAR     = 6'd15;
  localparam kind_t K_STAR_EQ  = 6'd16;
  localparam kind_t K_SLASH    = 6'd17;
  localparam kind_t K_SLASH_EQ = 6'd18;
  localparam kind_t K_PCT      = 6'd19;
  localparam kind_t K_PCT_EQ   = 6'd20;
  localparam kind_t K_GT       = 6'd21;
  localparam kind_t K_GE       = 6'd22;
  localparam kind_t K_LT       = 6'd23;
  localparam kind_t K_LE       = 6'd24;
  localparam kind_t K_SHR      = 6'd25;
  localparam kind_t K_SHR_EQ   = 6'd26;
  localparam kind_t K_SHL      = 6'd27;
  localparam kind_t K_SHL_EQ   = 6'd28;
  localparam kind_t K_BAR      = 6'd29;
  localparam kind_t K_BAR_EQ   = 6'd30;
  localparam kind_t K_OROR     = 6'd31;
  localparam kind_t K_AMP      = 6'd32;
  localparam kind_t K_AMP_EQ   = 6'd33;
  localparam kind_t K_ANDAND   = 6'd34;
  localparam kind_t K_BANG     = 6'd35;
  localparam kind_t K_NE       = 6'd36;
  localparam kind_t K_TILDE    = 6'd37;
  localparam kind_t K_ASSIGN   = 6'd38;
  localparam kind_t K_EQEQ     = 6'd39;
  localparam kind_t K_CARET    = 6'd40;
  localparam kind_t K_CARET_EQ = 6'd41;
  localparam kind_t K_HASH     = 6'd42;
  localparam kind_t K_HASHHASH = 6'd43;
  localparam kind_t K_LBRACK   = 6'd44;
  localparam kind_t K_RBRACK   = 6'd45;
  localparam kind_t K_LPAREN   = 6'd46;
  localparam kind_t K_RPAREN   = 6'd47;
  localparam kind_t K_LBRACE   = 6'd48;
  localparam kind_t K_RBRACE   = 6'd49;
  localparam kind_t K_COMMA    = 6'd50;
  localparam kind_t K_COLON    = 6'd51;
  localparam kind_t K_SEMI     = 6'd52;
  localparam kind_t K_QUEST    = 6'd53;
  localparam kind_t K_OTHER    = 6'd54;
  localparam kind_t K_EOI      = 6'd55;

  localparam err_t ERR_NONE    = 2'd0;
  localparam err_t ERR_LIT_NL  = 2'd1;
  localparam err_t ERR_LIT_EOI = 2'd2;
  localparam err_t ERR_CMT_EOI = 2'd3;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL  = 8'h0a;
  localparam logic [7:0] CH_VT  = 8'h0b;

  typedef struct packed {
    scan_op_e    op;
    scan_state_e nx;
    kind_t       kd;
  } dec_t;

  // results produced by one transaction, slot 0 first
  typedef struct packed {
    logic [1:0]            n;
    kind_t [MAX_RES-1:0]   kind;
    err_t  [MAX_RES-1:0]   err;
  } scan_res_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  // operator that may take one more byte
  function automatic dec_t pair_op(dec_t d, logic hit, kind_t k_hit, kind_t k_miss);
    dec_t r;
    r = d;
    if (hit) begin
      r.op = OP_TAKE;
      r.kd = k_hit;
    end else begin
      r.op = OP_STOP;
      r.kd = k_miss;
    end
    return r;
  endfunction

  function automatic dec_t scan_decide(scan_state_e st, logic [7:0] c);
    dec_t d;
    logic eq;
    d.op = OP_GO;
    d.nx = st;
    d.kd = K_OTHER;
    eq   = (c == "=");
    unique case (st)
      Q_IDENT: begin
        if (!is_word(c)) begin
          d.op = OP_STOP;
          d.kd = K_NAME;
        end
      end
      Q_NUM: begin
        if (c == "e" || c == "E") d.nx = Q_EXP;
        else if (!(is_alpha(c) || is_digit(c) || c == ".")) begin
          d.op = OP_STOP;
          d.kd = K_NUMBER;
        end
      end
      Q_EXP: begin
        if (c == "+" || c == "-" || is_alpha(c) || is_digit(c)) d.nx = Q_NUM;
        else begin
          d.op = OP_STOP;
          d.kd = K_NUMBER;
        end
      end
      Q_DOT: begin
        if (is_digit(c)) d.nx = Q_NUM;
        else if (c == ".") d.nx = Q_DOTDOT;
        else begin
          d.op = OP_STOP;
          d.kd = K_DOT;
        end
      end
      Q_DOTDOT: begin
        if (c == ".") begin
          d.op = OP_TAKE;
          d.kd = K_ELLIPSIS;
        end else begin
          d.op = OP_DOTS;
        end
      end
      Q_WIDE: begin
        if (c == "\"") d.nx = Q_STR;
        else if (c == "'") d.nx = Q_CHR;
        else if (is_word(c)) d.nx = Q_IDENT;
        else begin
          d.op = OP_STOP;
          d.kd = K_NAME;
        end
      end
      Q_STR, Q_STRESC: begin
        if (c == CH_NL) begin
          d.op = OP_LITNL;
          d.kd = K_STRING;
        end else if (st == Q_STR && c == "\"") begin
          d.op = OP_TAKE;
          d.kd = K_STRING;
        end else if (st == Q_STR && c == "\\") begin
          d.nx = Q_STRESC;
        end else begin
          d.nx = Q_STR;
        end
      end
      Q_CHR, Q_CHRESC: begin
        if (c == CH_NL) begin
          d.op = OP_LITNL;
          d.kd = K_CHAR;
        end else if (st == Q_CHR && c == "'") begin
          d.op = OP_TAKE;
          d.kd = K_CHAR;
        end else if (st == Q_CHR && c == "\\") begin
          d.nx = Q_CHRESC;
        end else begin
          d.nx = Q_CHR;
        end
      end
      Q_SPACE: begin
        if (!(c == " " || c == CH_TAB || c == CH_VT)) begin
          d.op = OP_STOP;
          d.kd = K_WS;
        end
      end
      Q_PLUS: begin
        if (c == "+") begin
          d.op = OP_TAKE;
          d.kd = K_INC;
        end else d = pair_op(d, eq, K_PLUS_EQ, K_PLUS);
      end
      Q_MINUS: begin
        if (c == "-") begin
          d.op = OP_TAKE;
          d.kd = K_DEC;
        end else if (c == ">") begin
          d.op = OP_TAKE;
          d.kd = K_ARROW;
        end else d = pair_op(d, eq, K_MINUS_EQ, K_MINUS);
      end
      Q_SLASH: begin
        if (c == "*") d.nx = Q_BLOCK;
        else if (c == "/") d.nx = Q_LINECMT;
        else d = pair_op(d, eq, K_SLASH_EQ, K_SLASH);
      end
      Q_BLOCK, Q_BLOCKSTAR: begin
        if (c == CH_NL) begin
          d.op = OP_CMTNL;
          d.nx = Q_BLOCK;
        end else if (st == Q_BLOCKSTAR && c == "/") begin
          d.op = OP_CMTEND;
        end else begin
          d.nx = (c == "*") ? Q_BLOCKSTAR : Q_BLOCK;
        end
      end
      Q_LINECMT: begin
        if (c == CH_NL) d.op = OP_LINEEND;
      end
      Q_STAR:  d = pair_op(d, eq, K_STAR_EQ, K_STAR);
      Q_PCT:   d = pair_op(d, eq, K_PCT_EQ, K_PCT);
      Q_GT: begin
        if (c == ">") d.nx = Q_GTGT;
        else d = pair_op(d, eq, K_GE, K_GT);
      end
      Q_GTGT:  d = pair_op(d, eq, K_SHR_EQ, K_SHR);
      Q_LT: begin
        if (c == "<") d.nx = Q_LTLT;
        else d = pair_op(d, eq, K_LE, K_LT);
      end
      Q_LTLT:  d = pair_op(d, eq, K_SHL_EQ, K_SHL);
      Q_BAR: begin
        if (c == "|") begin
          d.op = OP_TAKE;
          d.kd = K_OROR;
        end else d = pair_op(d, eq, K_BAR_EQ, K_BAR);
      end
      Q_AMP: begin
        if (c == "&") begin
          d.op = OP_TAKE;
          d.kd = K_ANDAND;
        end else d = pair_op(d, eq, K_AMP_EQ, K_AMP);
      end
      Q_BANG:  d = pair_op(d, eq, K_NE, K_BANG);
      Q_EQ:    d = pair_op(d, eq, K_EQEQ, K_ASSIGN);
      Q_CARET: d = pair_op(d, eq, K_CARET_EQ, K_CARET);
      Q_HASH:  d = pair_op(d, c == "#", K_HASHHASH, K_HASH);
      default: begin
        // start state
        if (c == "L") d.nx = Q_WIDE;
        else if (is_alpha(c) || c == "_") d.nx = Q_IDENT;
        else if (is_digit(c)) d.nx = Q_NUM;
        else begin
          d.op = OP_TAKE;
          unique case (c) inside
            ".":                d.op = OP_GO;
            "\"":               d.op = OP_GO;
            "'":                d.op = OP_GO;
            " ", CH_TAB, CH_VT: d.op = OP_GO;
            "+", "-", "/", "*", "%", ">", "<", "|", "&", "!", "=", "^", "#":
                                d.op = OP_GO;
            CH_NL:              d.op = OP_NL;
            "~":                d.kd = K_TILDE;
            "[":                d.kd = K_LBRACK;
            "]":                d.kd = K_RBRACK;
            "(":                d.kd = K_LPAREN;
            ")":                d.kd = K_RPAREN;
            "{":                d.kd = K_LBRACE;
            "}":                d.kd = K_RBRACE;
            ",":                d.kd = K_COMMA;
            ":":                d.kd = K_COLON;
            ";":                d.kd = K_SEMI;
            "?":                d.kd = K_QUEST;
            default:            d.kd = K_OTHER;
          endcase
          case (c)
            ".":     d.nx = Q_DOT;
            "\"":    d.nx = Q_STR;
            "'":     d.nx = Q_CHR;
            " ":     d.nx = Q_SPACE;
            CH_TAB:  d.nx = Q_SPACE;
            CH_VT:   d.nx = Q_SPACE;
            "+":     d.nx = Q_PLUS;
            "-":     d.nx = Q_MINUS;
            "/":     d.nx = Q_SLASH;
            "*":     d.nx = Q_STAR;
            "%":     d.nx = Q_PCT;
            ">":     d.nx = Q_GT;
            "<":     d.nx = Q_LT;
            "|":     d.nx = Q_BAR;
            "&":     d.nx = Q_AMP;
            "!":     d.nx = Q_BANG;
            "=":     d.nx = Q_EQ;
            "^":     d.nx = Q_CARET;
            "#":     d.nx = Q_HASH;
            default: d.nx = Q_IDLE;
          endcase
        end
      end
    endcase
    return d;
  endfunction

endpackage

// ----- design/ctok_scan.sv -----
// ----------------------------------------------------------------------------
// ctok_scan
// Scanner state, token length and line count; works out the results of one
// source byte, including the replay of a byte that ends a token.
// ----------------------------------------------------------------------------
module ctok_scan #(
  parameter int unsigned LEN_BITS  = ctok_pkg::LEN_BITS_DEF,
  parameter int unsigned LINE_BITS = ctok_pkg::LINE_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   take_i,
  input  logic [7:0]                             src_byte_i,
  input  logic                                   end_of_input_i,
  output ctok_pkg::scan_res_t                    res_o,
  output logic [ctok_pkg::MAX_RES-1:0][LEN_BITS-1:0] len_o,
  output logic [LINE_BITS-1:0]                   line_o
);
  import ctok_pkg::*;

  scan_state_e          state_q, state_d;
  logic [LEN_BITS-1:0]  len_q, len_d, len_inc;
  logic [LINE_BITS-1:0] line_q, line_d;
  dec_t                 dec_cur, dec_idle, dec_end;
  logic                 again;
  logic [1:0]           n;

  assign dec_cur  = scan_decide(state_q, src_byte_i);
  assign dec_idle = scan_decide(Q_IDLE, src_byte_i);
  // kind of an unfinished token cut off by end of input
  assign dec_end  = scan_decide(state_q, CH_NUL);
  assign len_inc  = (len_q == {LEN_BITS{1'b1}}) ? len_q : len_q + LEN_BITS'(1);

  always_comb begin
    n           = 2'd0;
    res_o.kind  = '0;
    res_o.err   = '0;
    len_o       = '0;
    state_d     = state_q;
    len_d       = len_q;
    line_d      = line_q;
    again       = 1'b0;
    if (end_of_input_i) begin
      if (state_q == Q_STR || state_q == Q_STRESC || state_q == Q_CHR ||
          state_q == Q_CHRESC) begin
        res_o.kind[n] = K_EOI;
        res_o.err[n]  = ERR_LIT_EOI;
        n = n + 2'd1;
      end else if (state_q == Q_BLOCK || state_q == Q_BLOCKSTAR ||
                   state_q == Q_LINECMT) begin
        res_o.kind[n] = K_EOI;
        res_o.err[n]  = ERR_CMT_EOI;
        n = n + 2'd1;
      end else begin
        if (state_q == Q_DOTDOT) begin
          res_o.kind[n] = K_DOT;
          len_o[n]      = LEN_BITS'(1);
          n = n + 2'd1;
          res_o.kind[n] = K_DOT;
          len_o[n]      = LEN_BITS'(1);
          n = n + 2'd1;
        end else if (state_q != Q_IDLE) begin
          res_o.kind[n] = dec_end.kd;
          len_o[n]      = len_q;
          n = n + 2'd1;
        end
        res_o.kind[n] = K_EOI;
        n = n + 2'd1;
      end
      state_d = Q_IDLE;
      len_d   = '0;
    end else begin
      case (dec_cur.op)
        OP_GO: begin
          state_d = dec_cur.nx;
          len_d   = len_inc;
        end
        OP_TAKE: begin
          res_o.kind[n] = dec_cur.kd;
          len_o[n]      = len_inc;
          n = n + 2'd1;
          state_d = Q_IDLE;
          len_d   = '0;
        end
        OP_STOP: begin
          res_o.kind[n] = dec_cur.kd;
          len_o[n]      = len_q;
          n = n + 2'd1;
          again = 1'b1;
        end
        OP_NL: begin
          res_o.kind[n] = K_NL;
          len_o[n]      = LEN_BITS'(1);
          n = n + 2'd1;
          line_d  = line_q + LINE_BITS'(1);
          state_d = Q_IDLE;
          len_d   = '0;
        end
        OP_CMTNL: begin
          line_d  = line_q + LINE_BITS'(1);
          state_d = Q_BLOCK;
        end
        OP_CMTEND: begin
          state_d = Q_IDLE;
          len_d   = '0;
        end
        OP_LITNL: begin
          res_o.kind[n] = dec_cur.kd;
          res_o.err[n]  = ERR_LIT_NL;
          len_o[n]      = len_q;
          n = n + 2'd1;
          again = 1'b1;
        end
        OP_DOTS: begin
          res_o.kind[n] = K_DOT;
          len_o[n]      = LEN_BITS'(1);
          n = n + 2'd1;
          res_o.kind[n] = K_DOT;
          len_o[n]      = LEN_BITS'(1);
          n = n + 2'd1;
          again = 1'b1;
        end
        default: again = 1'b1;
      endcase
      // the byte that ended a token is scanned again from the start state
      if (again) begin
        state_d = Q_IDLE;
        len_d   = '0;
        case (dec_idle.op)
          OP_GO: begin
            state_d = dec_idle.nx;
            len_d   = LEN_BITS'(1);
          end
          OP_TAKE: begin
            res_o.kind[n] = dec_idle.kd;
            len_o[n]      = LEN_BITS'(1);
            n = n + 2'd1;
          end
          OP_NL: begin
            res_o.kind[n] = K_NL;
            len_o[n]      = LEN_BITS'(1);
            n = n + 2'd1;
            line_d = line_q + LINE_BITS'(1);
          end
          default: state_d = Q_IDLE;
        endcase
      end
    end
    res_o.n = n;
  end

  assign line_o = line_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Q_IDLE;
      len_q   <= '0;
      line_q  <= '0;
    end else if (take_i) begin
      state_q <= state_d;
      len_q   <= len_d;
      line_q  <= line_d;
    end
  end

  a_idle_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && end_of_input_i |=> state_q == Q_IDLE && len_q == '0)
    else $error("scanner not idle after end of input");

  a_end_keeps_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && end_of_input_i |=> line_q == $past(line_q))
    else $error("line count moved on end of input");

  a_end_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_of_input_i |-> res_o.n != 2'd0 && res_o.kind[res_o.n - 2'd1] == K_EOI)
    else $error("end of input without closing result");

endmodule

// ----- design/c_token_lexer_top.sv -----
// ----------------------------------------------------------------------------
// c_token_lexer_top
// C preprocessor tokenizer taking one source byte per transaction. Each byte
// is decoded in the cycle it is accepted: the scanner state, token length and
// line count update at once and the zero to three results it causes are
// loaded into a three-slot result register, drained one per cycle while the
// receiver is ready. A new byte is accepted whenever the result register is
// empty or its last result leaves in the same cycle, so bytes that cause at
// most one result stream at one per cycle; larger runs stall the next byte.
// Results carry the kind, byte length (saturating), line number before the
// token end, an error code and a flag on the last result of each byte.
// ----------------------------------------------------------------------------
module c_token_lexer_top #(
  parameter int unsigned LEN_BITS  = ctok_pkg::LEN_BITS_DEF,
  parameter int unsigned LINE_BITS = ctok_pkg::LINE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           src_byte_i,
  input  logic                 end_of_input_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [5:0]           token_kind_o,
  output logic [LEN_BITS-1:0]  token_len_o,
  output logic [LINE_BITS-1:0] line_number_o,
  output logic [1:0]           error_code_o,
  output logic                 last_of_run_o
);
  import ctok_pkg::*;

  scan_res_t                          scan_res;
  logic [MAX_RES-1:0][LEN_BITS-1:0]   scan_len;
  logic [LINE_BITS-1:0]               scan_line;
  logic                               take, fire;

  // result slots, slot 0 is on the output
  logic [1:0]                         cnt_q;
  kind_t [MAX_RES-1:0]                kind_q;
  err_t  [MAX_RES-1:0]                err_q;
  logic [MAX_RES-1:0][LEN_BITS-1:0]   len_q;
  logic [LINE_BITS-1:0]               line_q;

  assign fire       = out_valid_o && out_ready_i;
  assign in_ready_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready_i);
  assign take       = in_valid_i && in_ready_o;

  ctok_scan #(
    .LEN_BITS  (LEN_BITS),
    .LINE_BITS (LINE_BITS)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .src_byte_i     (src_byte_i),
    .end_of_input_i (end_of_input_i),
    .res_o          (scan_res),
    .len_o          (scan_len),
    .line_o         (scan_line)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (take) begin
      cnt_q <= scan_res.n;
    end else if (fire) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q <= scan_res.kind;
      err_q  <= scan_res.err;
      len_q  <= scan_len;
      line_q <= scan_line;
    end else if (fire) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        kind_q[i] <= kind_q[i+1];
        err_q[i]  <= err_q[i+1];
        len_q[i]  <= len_q[i+1];
      end
    end
  end

  assign out_valid_o   = cnt_q != 2'd0;
  assign token_kind_o  = kind_q[0];
  assign token_len_o   = len_q[0];
  assign line_number_o = line_q;
  assign error_code_o  = err_q[0];
  assign last_of_run_o = cnt_q == 2'd1;

  a_load_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> cnt_q == $past(scan_res.n))
    else $error("result count not loaded from scanner");

  a_drain_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !last_of_run_o |=> out_valid_o && !$past(take))
    else $error("results dropped before the last of a run");

  a_end_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && end_of_input_i |=> out_valid_o)
    else $error("end of input gave no result");

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the C token lexer. A directed table walks chosen
// scanner paths and the error cases, then C-like text with random damage
// runs under several sender and receiver idle mixes. Every result is checked
// against a cycle-free predictor of the scanner.
// ----------------------------------------------------------------------------
module tb;
  import ctok_pkg::*;

  localparam int unsigned LEN_W    = LEN_BITS_DEF;
  localparam int unsigned LINE_W   = LINE_BITS_DEF;
  localparam int          NUM_DIR  = 29;
  localparam int          NUM_FRAG = 22;
  localparam int          HOLD_LEN = 300;

  typedef struct packed {
    scan_op_e    op;
    scan_state_e nxt;
    kind_t       kind;
  } move_t;

  typedef struct packed {
    kind_t             kind;
    logic [LEN_W-1:0]  len;
    logic [LINE_W-1:0] line;
    err_t              err;
    logic              last;
  } tok_t;

  typedef struct packed {
    logic [7:0]       sym;
    logic             eoi;
    logic             chk;
    kind_t            kind;
    logic [LEN_W-1:0] len;
    err_t             err;
  } dir_row_t;

  // chk rows carry the last token that the byte produces
  localparam dir_row_t DIR_TAB [NUM_DIR] = '{
    '{8'h00,  1'b0, 1'b1, K_OTHER,  16'd1, ERR_NONE},  // unknown byte
    '{8'hff,  1'b0, 1'b1, K_OTHER,  16'd1, ERR_NONE},
    '{"\\",   1'b0, 1'b1, K_OTHER,  16'd1, ERR_NONE},
    '{"L",    1'b0, 1'b0, K_NAME,   16'd0, ERR_NONE},  // wide char literal
    '{"'",    1'b0, 1'b0, K_NAME,   16'd0, ERR_NONE},
    '{8'hfe,  1'b0, 1'b0, K_NAME,   16'd0, ERR_NONE},
    '{"'",    1'b0, 1'b1, K_CHAR,   16'd4, ERR_NONE},
    '{".",    1'b0, 1'b0, K_NAME,   16'd0, ERR_NONE},  // two dots, no third
    '{".",    1'b0, 1'b0, K_NAME,   16'd0, ERR_NONE},
    '{"L",    1'b0, 1'b1, K_DOT,    16'd1, ERR_NONE},
    '{"a",    1'b0, 1'b0, K_NAME,   16'd0, ERR_NONE},  // L then letter is a name
    '{"\"",   1'b0, 1'b1, K_NAME,   16'd2, ERR_NONE},
    '{CH_NL,  1'b0, 1'b1, K_NL,     16'd1, ERR_NONE},  // newline inside string
    '{"/",    1'b0, 1'b0, K_NAME,   16'd0, ERR_NONE},  // line comment
    '{"/",    1'b0, 1'b0, K_NAME,   16'd0, ERR_NONE},
    '{CH_NL,  1'b0, 1'b1, K_NL,     16'd1, ERR_NONE},
    '{"/",    1'b0, 1'b0, K_NAME,   16'd0, ERR_NONE},  // block comment, extra star
    '{"*",    1'b0, 1'b0, K_NAME,   16'd0, ERR_NONE},
    '{CH_NL,  1'b0, 1'b0, K_NAME,   16'd0, ERR_NONE},
    '{"*",    1'b0, 1'b0, K_NAME,   16'd0, ERR_NONE},
    '{"*",    1'b0, 1'b0, K_NAME,   16'd0, ERR_NONE},
    '{"/",    1'b0, 1'b0, K_NAME,   16'd0, ERR_NONE},
    '{"/",    1'b0, 1'b0, K_NAME,   16'd0, ERR_NONE},
    '{"*",    1'b0, 1'b0, K_NAME,   16'd0, ERR_NONE},
    '{8'h5a,  1'b1, 1'b1, K_EOI,    16'd0, ERR_CMT_EOI},
    '{"'",    1'b0, 1'b0, K_NAME,   16'd0, ERR_NONE},
    '{8'h00,  1'b1, 1'b1, K_EOI,    16'd0, ERR_LIT_EOI},
    '{"+",    1'b0, 1'b0, K_NAME,   16'd0, ERR_NONE},
    '{8'hff,  1'b1, 1'b1, K_EOI,    16'd0, ERR_NONE}
  };

  string frags [NUM_FRAG] = '{
    "int x1 = a+b;\n", "/* note ** */", "// tail\n", "L'q'", "L\"wide\"",
    "\"s\\\"t\"", "'\\n'", "1.5e+3 ", ".25", "x->y--", "a>>=b<<=c",
    "p&&q||r", "#define f(a) a##b\n", "...", "..x", "i+=2;j-=3;k*=4;",
    "m%=n^=o|=p&=q!=r==s<=t>=u", "/**/", "\"open\n", "\t\v x",
    "~[]{}(),:;?", "'c\n"
  };
  string charset = "aLeE_z09.\"'\\ \t\v\n+-*/%<>=!&|^#~[](){},:;?@$";

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid     = 1'b0;
  logic [7:0]        src_byte     = 8'h00;
  logic              end_of_input = 1'b0;
  logic              out_ready    = 1'b0;
  wire               in_ready_o;
  wire               out_valid_o;
  wire [5:0]         token_kind_o;
  wire [LEN_W-1:0]   token_len_o;
  wire [LINE_W-1:0]  line_number_o;
  wire [1:0]         error_code_o;
  wire               last_of_run_o;

  // typed expectation riding along with the current input transaction
  logic              tab_chk  = 1'b0;
  kind_t             tab_kind = K_NAME;
  logic [LEN_W-1:0]  tab_len  = '0;
  err_t              tab_err  = ERR_NONE;

  scan_state_e       lex_st   = Q_IDLE;
  logic [LEN_W-1:0]  lex_len  = '0;
  logic [LINE_W-1:0] lex_line = '0;
  tok_t              step_toks [$];
  tok_t              tokens_due [$];

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_req     = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int fail_cnt     = 0;

  c_token_lexer_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .src_byte_i     (src_byte),
    .end_of_input_i (end_of_input),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .token_kind_o   (token_kind_o),
    .token_len_o    (token_len_o),
    .line_number_o  (line_number_o),
    .error_code_o   (error_code_o),
    .last_of_run_o  (last_of_run_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(string msg);
    fail_cnt++;
    if (fail_cnt <= 40) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, longint got, longint want);
    if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  function automatic logic alpha_ch(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic digit_ch(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic ident_ch(logic [7:0] c);
    return alpha_ch(c) || digit_ch(c) || c == "_";
  endfunction

  function automatic move_t end_or_take(logic [7:0] c, logic [7:0] second,
                                        kind_t k_two, kind_t k_one);
    move_t m;
    m.nxt = Q_IDLE;
    if (c == second) begin
      m.op   = OP_TAKE;
      m.kind = k_two;
    end else begin
      m.op   = OP_STOP;
      m.kind = k_one;
    end
    return m;
  endfunction

  function automatic move_t from_idle(logic [7:0] c);
    move_t m;
    m.op   = OP_GO;
    m.nxt  = Q_IDLE;
    m.kind = K_OTHER;
    if (c == "L") m.nxt = Q_WIDE;
    else if (alpha_ch(c) || c == "_") m.nxt = Q_IDENT;
    else if (digit_ch(c)) m.nxt = Q_NUM;
    else begin
      case (c)
        ".":                m.nxt = Q_DOT;
        "\"":               m.nxt = Q_STR;
        "'":                m.nxt = Q_CHR;
        " ", CH_TAB, CH_VT: m.nxt = Q_SPACE;
        "+":                m.nxt = Q_PLUS;
        "-":                m.nxt = Q_MINUS;
        "/":                m.nxt = Q_SLASH;
        "*":                m.nxt = Q_STAR;
        "%":                m.nxt = Q_PCT;
        ">":                m.nxt = Q_GT;
        "<":                m.nxt = Q_LT;
        "|":                m.nxt = Q_BAR;
        "&":                m.nxt = Q_AMP;
        "!":                m.nxt = Q_BANG;
        "=":                m.nxt = Q_EQ;
        "^":                m.nxt = Q_CARET;
        "#":                m.nxt = Q_HASH;
        CH_NL:              m.op  = OP_NL;
        default: begin
          m.op = OP_TAKE;
          case (c)
            "~":     m.kind = K_TILDE;
            "[":     m.kind = K_LBRACK;
            "]":     m.kind = K_RBRACK;
            "(":     m.kind = K_LPAREN;
            ")":     m.kind = K_RPAREN;
            "{":     m.kind = K_LBRACE;
            "}":     m.kind = K_RBRACE;
            ",":     m.kind = K_COMMA;
            ":":     m.kind = K_COLON;
            ";":     m.kind = K_SEMI;
            "?":     m.kind = K_QUEST;
            default: m.kind = K_OTHER;
          endcase
        end
      endcase
    end
    return m;
  endfunction

  function automatic move_t next_move(scan_state_e st, logic [7:0] c);
    move_t m;
    m.op   = OP_GO;
    m.nxt  = st;
    m.kind = K_OTHER;
    case (st)
      Q_IDENT: begin
        if (!ident_ch(c)) begin
          m.op   = OP_STOP;
          m.kind = K_NAME;
        end
      end
      Q_NUM: begin
        if (c == "e" || c == "E") m.nxt = Q_EXP;
        else if (!(alpha_ch(c) || digit_ch(c) || c == ".")) begin
          m.op   = OP_STOP;
          m.kind = K_NUMBER;
        end
      end
      Q_EXP: begin
        if (c == "+" || c == "-" || alpha_ch(c) || digit_ch(c)) m.nxt = Q_NUM;
        else begin
          m.op   = OP_STOP;
          m.kind = K_NUMBER;
        end
      end
      Q_DOT: begin
        if (digit_ch(c)) m.nxt = Q_NUM;
        else if (c == ".") m.nxt = Q_DOTDOT;
        else begin
          m.op   = OP_STOP;
          m.kind = K_DOT;
        end
      end
      Q_DOTDOT: begin
        if (c == ".") begin
          m.op   = OP_TAKE;
          m.kind = K_ELLIPSIS;
        end else m.op = OP_DOTS;
      end
      Q_WIDE: begin
        if (c == "\"") m.nxt = Q_STR;
        else if (c == "'") m.nxt = Q_CHR;
        else if (ident_ch(c)) m.nxt = Q_IDENT;
        else begin
          m.op   = OP_STOP;
          m.kind = K_NAME;
        end
      end
      Q_STR, Q_STRESC: begin
        if (c == CH_NL) begin
          m.op   = OP_LITNL;
          m.kind = K_STRING;
        end else if (st == Q_STR && c == "\"") begin
          m.op   = OP_TAKE;
          m.kind = K_STRING;
        end else if (st == Q_STR && c == "\\") m.nxt = Q_STRESC;
        else m.nxt = Q_STR;
      end
      Q_CHR, Q_CHRESC: begin
        if (c == CH_NL) begin
          m.op   = OP_LITNL;
          m.kind = K_CHAR;
        end else if (st == Q_CHR && c == "'") begin
          m.op   = OP_TAKE;
          m.kind = K_CHAR;
        end else if (st == Q_CHR && c == "\\") m.nxt = Q_CHRESC;
        else m.nxt = Q_CHR;
      end
      Q_SPACE: begin
        if (!(c == " " || c == CH_TAB || c == CH_VT)) begin
          m.op   = OP_STOP;
          m.kind = K_WS;
        end
      end
      Q_PLUS: begin
        if (c == "+") begin
          m.op   = OP_TAKE;
          m.kind = K_INC;
        end else m = end_or_take(c, "=", K_PLUS_EQ, K_PLUS);
      end
      Q_MINUS: begin
        if (c == "-") begin
          m.op   = OP_TAKE;
          m.kind = K_DEC;
        end else if (c == ">") begin
          m.op   = OP_TAKE;
          m.kind = K_ARROW;
        end else m = end_or_take(c, "=", K_MINUS_EQ, K_MINUS);
      end
      Q_SLASH: begin
        if (c == "*") m.nxt = Q_BLOCK;
        else if (c == "/") m.nxt = Q_LINECMT;
        else m = end_or_take(c, "=", K_SLASH_EQ, K_SLASH);
      end
      Q_BLOCK, Q_BLOCKSTAR: begin
        if (c == CH_NL) begin
          m.op  = OP_CMTNL;
          m.nxt = Q_BLOCK;
        end else if (st == Q_BLOCKSTAR && c == "/") m.op = OP_CMTEND;
        else m.nxt = (c == "*") ? Q_BLOCKSTAR : Q_BLOCK;
      end
      Q_LINECMT: begin
        if (c == CH_NL) m.op = OP_LINEEND;
      end
      Q_STAR:  m = end_or_take(c, "=", K_STAR_EQ, K_STAR);
      Q_PCT:   m = end_or_take(c, "=", K_PCT_EQ, K_PCT);
      Q_GT: begin
        if (c == ">") m.nxt = Q_GTGT;
        else m = end_or_take(c, "=", K_GE, K_GT);
      end
      Q_GTGT:  m = end_or_take(c, "=", K_SHR_EQ, K_SHR);
      Q_LT: begin
        if (c == "<") m.nxt = Q_LTLT;
        else m = end_or_take(c, "=", K_LE, K_LT);
      end
      Q_LTLT:  m = end_or_take(c, "=", K_SHL_EQ, K_SHL);
      Q_BAR: begin
        if (c == "|") begin
          m.op   = OP_TAKE;
          m.kind = K_OROR;
        end else m = end_or_take(c, "=", K_BAR_EQ, K_BAR);
      end
      Q_AMP: begin
        if (c == "&") begin
          m.op   = OP_TAKE;
          m.kind = K_ANDAND;
        end else m = end_or_take(c, "=", K_AMP_EQ, K_AMP);
      end
      Q_BANG:  m = end_or_take(c, "=", K_NE, K_BANG);
      Q_EQ:    m = end_or_take(c, "=", K_EQEQ, K_ASSIGN);
      Q_CARET: m = end_or_take(c, "=", K_CARET_EQ, K_CARET);
      Q_HASH:  m = end_or_take(c, "#", K_HASHHASH, K_HASH);
      default: m = from_idle(c);
    endcase
    return m;
  endfunction

  function automatic void emit_tok(kind_t k, logic [LEN_W-1:0] l, err_t e);
    tok_t t;
    t.kind = k;
    t.len  = l;
    t.line = lex_line;
    t.err  = e;
    t.last = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic void grow_len();
    if (lex_len != {LEN_W{1'b1}}) lex_len = lex_len + 1'b1;
  endfunction

  // scan one byte, collect its tokens in step_toks and queue them
  function automatic void lex_byte(logic [7:0] c, logic eoi);
    scan_state_e st;
    move_t       m;
    logic        again;
    int          pass;
    step_toks.delete();
    st = lex_st;
    if (eoi) begin
      if (st inside {Q_STR, Q_STRESC, Q_CHR, Q_CHRESC}) begin
        emit_tok(K_EOI, '0, ERR_LIT_EOI);
      end else if (st inside {Q_BLOCK, Q_BLOCKSTAR, Q_LINECMT}) begin
        emit_tok(K_EOI, '0, ERR_CMT_EOI);
      end else begin
        if (st == Q_DOTDOT) begin
          emit_tok(K_DOT, LEN_W'(1), ERR_NONE);
          emit_tok(K_DOT, LEN_W'(1), ERR_NONE);
        end else if (st != Q_IDLE) begin
          m = next_move(st, CH_NUL);
          emit_tok(m.kind, lex_len, ERR_NONE);
        end
        emit_tok(K_EOI, '0, ERR_NONE);
      end
      st      = Q_IDLE;
      lex_len = '0;
    end else begin
      for (pass = 0; pass < 2; pass++) begin
        m     = next_move(st, c);
        again = 1'b0;
        case (m.op)
          OP_GO: begin
            st = m.nxt;
            grow_len();
          end
          OP_TAKE: begin
            grow_len();
            emit_tok(m.kind, lex_len, ERR_NONE);
            st      = Q_IDLE;
            lex_len = '0;
          end
          OP_STOP: begin
            emit_tok(m.kind, lex_len, ERR_NONE);
            st      = Q_IDLE;
            lex_len = '0;
            again   = 1'b1;
          end
          OP_NL: begin
            emit_tok(K_NL, LEN_W'(1), ERR_NONE);
            lex_line = lex_line + 1'b1;
            st       = Q_IDLE;
            lex_len  = '0;
          end
          OP_CMTNL: begin
            lex_line = lex_line + 1'b1;
            st       = Q_BLOCK;
          end
          OP_CMTEND: begin
            st      = Q_IDLE;
            lex_len = '0;
          end
          OP_LITNL: begin
            emit_tok(m.kind, lex_len, ERR_LIT_NL);
            st      = Q_IDLE;
            lex_len = '0;
            again   = 1'b1;
          end
          OP_DOTS: begin
            emit_tok(K_DOT, LEN_W'(1), ERR_NONE);
            emit_tok(K_DOT, LEN_W'(1), ERR_NONE);
            st      = Q_IDLE;
            lex_len = '0;
            again   = 1'b1;
          end
          default: begin
            // line comment ends before the newline, which is rescanned
            st      = Q_IDLE;
            lex_len = '0;
            again   = 1'b1;
          end
        endcase
        if (!again) break;
      end
    end
    lex_st = st;
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
    foreach (step_toks[i]) tokens_due.push_back(step_toks[i]);
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin : watch_io
    tok_t want;
    if (out_valid_o && out_ready) begin
      if (tokens_due.size() == 0) begin
        report_mismatch($sformatf("unexpected token kind %0d", token_kind_o));
      end else begin
        want = tokens_due.pop_front();
        check_field("token_kind", token_kind_o, want.kind);
        check_field("token_len", token_len_o, want.len);
        check_field("line_number", line_number_o, want.line);
        check_field("error_code", error_code_o, want.err);
        check_field("last_of_run", last_of_run_o, want.last);
      end
    end
    if (in_valid && in_ready_o) begin
      lex_byte(src_byte, end_of_input);
      if (tab_chk) begin
        if (step_toks.size() == 0) begin
          report_mismatch("table row predicts no token");
        end else begin
          want = step_toks[step_toks.size()-1];
          check_field("table kind", want.kind, tab_kind);
          check_field("table len", want.len, tab_len);
          check_field("table error", want.err, tab_err);
        end
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic eoi, input logic chk = 1'b0,
                           input kind_t k = K_NAME, input logic [LEN_W-1:0] l = '0,
                           input err_t e = ERR_NONE);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    src_byte     <= b;
    end_of_input <= eoi;
    tab_chk      <= chk;
    tab_kind     <= k;
    tab_len      <= l;
    tab_err      <= e;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_all_tokens();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (tokens_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // mostly C-like fragments with light damage, the rest noise and end marks
  task automatic random_text(int target);
    int         sent;
    int         pick;
    int         k;
    string      frag;
    logic [7:0] b;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        frag = frags[$urandom_range(NUM_FRAG-1)];
        for (k = 0; k < frag.len(); k++) begin
          b = frag[k];
          if ($urandom_range(9) == 0) b = charset[$urandom_range(charset.len()-1)];
          push_byte(b, 1'b0);
          sent++;
        end
        if ($urandom_range(19) == 0) begin
          push_byte(8'($urandom_range(255)), 1'b1);
          sent++;
        end
      end else if (pick < 88) begin
        push_byte(charset[$urandom_range(charset.len()-1)], 1'b0);
        sent++;
      end else if (pick < 96) begin
        push_byte(8'($urandom_range(255)), 1'b0);
        sent++;
      end else begin
        push_byte(8'($urandom_range(255)), 1'b1);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    int i;
    int ph;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < NUM_DIR; i++) begin
      push_byte(DIR_TAB[i].sym, DIR_TAB[i].eoi, DIR_TAB[i].chk,
                DIR_TAB[i].kind, DIR_TAB[i].len, DIR_TAB[i].err);
    end
    wait_all_tokens();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 82; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 82; end
        default: begin tx_idle_pct = 31; rx_stall_pct = 31; end
      endcase
      // fill the block while the receiver holds off
      if (ph == 0) hold_req++;
      random_text(50);
      wait_all_tokens();
    end

    if (tokens_due.size() != 0) report_mismatch("tokens left over at end");
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
